// ----- src/tatlt_pkg.sv -----
`default_nettype none
package tatlt_pkg;

	// Light colors as they appear on the result ports.
	typedef enum logic [1:0] {
		COL_GREEN  = 2'd0,
		COL_ORANGE = 2'd1,
		COL_RED    = 2'd2
	} color_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_GREEN_NS    = 2'd0,
		REG_GREEN_EO    = 2'd1,
		REG_ORANGE_TIME = 2'd2,
		REG_ALLRED_TIME = 2'd3
	} reg_idx_t;

	localparam int GREEN_W  = 8;
	localparam int PHASE_W  = 4;
	localparam int TIMER_W  = 9;
	localparam int CFG_DW   = 8;
	localparam int CFG_AW   = 2;

	// Reset values of the configuration registers.
	localparam logic [GREEN_W-1:0] RST_GREEN_NS    = 8'd10;
	localparam logic [GREEN_W-1:0] RST_GREEN_EO    = 8'd10;
	localparam logic [PHASE_W-1:0] RST_ORANGE_TIME = 4'd3;
	localparam logic [PHASE_W-1:0] RST_ALLRED_TIME = 4'd2;

	// Reset values of the two phase timers.
	localparam logic [TIMER_W-1:0] RST_TIMER_NS = {1'b0, RST_GREEN_NS};
	localparam logic [TIMER_W-1:0] RST_TIMER_EO = {1'b0, RST_GREEN_NS}
		+ {5'b00000, RST_ORANGE_TIME} + {5'b00000, RST_ALLRED_TIME};

	typedef struct packed {
		logic [GREEN_W-1:0] green_ns;
		logic [GREEN_W-1:0] green_eo;
		logic [PHASE_W-1:0] orange_time;
		logic [PHASE_W-1:0] allred_time;
	} cfg_t;

endpackage
`default_nettype wire

// ----- src/two_axis_traffic_light_timer.sv -----
// Two-axis traffic light timer. Each input transfer is one tick; restart high
// reloads the initial phase (north-south green for green_ns ticks, east-west
// red for green_ns + orange_time + allred_time ticks) instead of counting.
// Every tick gives exactly one result carrying both colors (0 green, 1 orange,
// 2 red) and both remaining times after the update. A tick can be taken every
// clock cycle while no result waits on a stalled output; its result passes
// through the input stage and then the light state register, which also serves
// as the result register. Configuration writes are always ready and should be
// made while no tick is in flight.
`default_nettype none
module two_axis_traffic_light_timer
	import tatlt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Tick input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               restart,
	// Result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              color_ns,
	output logic [1:0]              color_eo,
	output logic [TIMER_W-1:0]      remaining_ns,
	output logic [TIMER_W-1:0]      remaining_eo,
	// Configuration write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CFG_AW-1:0]  cfg_index,
	input  wire logic [CFG_DW-1:0]  cfg_data
);

	cfg_t               cfg;
	logic               valid_s1;
	logic               restart_s1;
	logic               adv;
	logic               out_valid_q;
	color_t             color_ns_q;
	color_t             color_eo_q;
	logic [TIMER_W-1:0] ns_timer_q;
	logic [TIMER_W-1:0] eo_timer_q;
	color_t             ns_color_tick;
	color_t             eo_color_tick;
	logic [TIMER_W-1:0] ns_timer_tick;
	logic [TIMER_W-1:0] eo_timer_tick;
	logic [TIMER_W-1:0] eo_restart_load;

	assign cfg_ready = 1'b1;

	tatlt_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The input stage moves on whenever the result slot is free or drains.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			restart_s1 <= restart;
		end
	end

	// Per-axis tick logic.
	tatlt_axis u_axis_ns (
		.color_cur   (color_ns_q),
		.timer_cur   (ns_timer_q),
		.own_green   (cfg.green_ns),
		.other_green (cfg.green_eo),
		.cfg         (cfg),
		.color_nxt   (ns_color_tick),
		.timer_nxt   (ns_timer_tick)
	);

	tatlt_axis u_axis_eo (
		.color_cur   (color_eo_q),
		.timer_cur   (eo_timer_q),
		.own_green   (cfg.green_eo),
		.other_green (cfg.green_ns),
		.cfg         (cfg),
		.color_nxt   (eo_color_tick),
		.timer_nxt   (eo_timer_tick)
	);

	assign eo_restart_load = {1'b0, cfg.green_ns} + {5'b00000, cfg.orange_time}
		+ {5'b00000, cfg.allred_time};

	// Light state; it is also the result register shown on the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_ns_q <= COL_GREEN;
			color_eo_q <= COL_RED;
			ns_timer_q <= RST_TIMER_NS;
			eo_timer_q <= RST_TIMER_EO;
		end else if (adv) begin
			if (restart_s1) begin
				color_ns_q <= COL_GREEN;
				color_eo_q <= COL_RED;
				ns_timer_q <= {1'b0, cfg.green_ns};
				eo_timer_q <= eo_restart_load;
			end else begin
				color_ns_q <= ns_color_tick;
				color_eo_q <= eo_color_tick;
				ns_timer_q <= ns_timer_tick;
				eo_timer_q <= eo_timer_tick;
			end
		end
	end

	// Result valid flag: set by a new result, cleared by an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign color_ns     = color_ns_q;
	assign color_eo     = color_eo_q;
	assign remaining_ns = ns_timer_q;
	assign remaining_eo = eo_timer_q;

	// The input side is held back only by a result that is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a waiting result");

	// An ordinary tick on a running north-south counter keeps the color and counts down.
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !restart_s1 && ns_timer_q > 9'd1) |=>
		(color_ns_q == $past(color_ns_q) && ns_timer_q == $past(ns_timer_q) - 9'd1))
		else $error("north-south counter did not count down");

	// A result only appears after the input stage moved on.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !adv) |=> !out_valid_q)
		else $error("result appeared without a tick");

endmodule
`default_nettype wire

// ----- src/tatlt_cfg_regs.sv -----
`default_nettype none
module tatlt_cfg_regs
	import tatlt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [CFG_AW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// A transfer updates the addressed register, truncated to its width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.green_ns    <= RST_GREEN_NS;
			cfg_q.green_eo    <= RST_GREEN_EO;
			cfg_q.orange_time <= RST_ORANGE_TIME;
			cfg_q.allred_time <= RST_ALLRED_TIME;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_GREEN_NS:    cfg_q.green_ns    <= cfg_data;
				REG_GREEN_EO:    cfg_q.green_eo    <= cfg_data;
				REG_ORANGE_TIME: cfg_q.orange_time <= cfg_data[PHASE_W-1:0];
				REG_ALLRED_TIME: cfg_q.allred_time <= cfg_data[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- src/tatlt_axis.sv -----
`default_nettype none
module tatlt_axis
	import tatlt_pkg::*;
(
	input  wire color_t             color_cur,
	input  wire logic [TIMER_W-1:0] timer_cur,
	input  wire logic [GREEN_W-1:0] own_green,
	input  wire logic [GREEN_W-1:0] other_green,
	input  wire cfg_t               cfg,
	output color_t               color_nxt,
	output logic [TIMER_W-1:0]   timer_nxt
);

	logic [TIMER_W-1:0] red_load;
	logic               expire;

	// Red lasts two all-red overlaps, one orange and the other axis's green.
	assign red_load = {4'b0000, cfg.allred_time, 1'b0}
		+ {5'b00000, cfg.orange_time} + {1'b0, other_green};

	// A counter at one or zero ends the phase on this tick.
	assign expire = (timer_cur <= 9'd1);

	always_comb begin
		color_nxt = color_cur;
		timer_nxt = timer_cur - 9'd1;
		if (expire) begin
			case (color_cur)
				COL_GREEN: begin
					color_nxt = COL_ORANGE;
					timer_nxt = {5'b00000, cfg.orange_time};
				end
				COL_ORANGE: begin
					color_nxt = COL_RED;
					timer_nxt = red_load;
				end
				COL_RED: begin
					color_nxt = COL_GREEN;
					timer_nxt = {1'b0, own_green};
				end
				default: begin
					color_nxt = COL_GREEN;
					timer_nxt = {1'b0, own_green};
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- verif/two_axis_traffic_light_timer_test.sv -----
module two_axis_traffic_light_timer_test;
	import tatlt_pkg::*;

	// The red load is twice the all-red overlap plus orange plus the other green.
	localparam int ALLRED_PER_CYCLE = 2;

	typedef struct packed {
		color_t               ns;
		color_t               eo;
		logic [TIMER_W-1:0]   ns_left;
		logic [TIMER_W-1:0]   eo_left;
	} light_report_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  restart = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            color_ns;
	logic [1:0]            color_eo;
	logic [TIMER_W-1:0]    remaining_ns;
	logic [TIMER_W-1:0]    remaining_eo;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_AW-1:0]     cfg_index = '0;
	logic [CFG_DW-1:0]     cfg_data = '0;

	// Stimulus and scoreboard storage.
	bit                    tick_queue[$];
	light_report_t         expected_lights[$];
	bit                    tick_taken = 1'b0;
	bit                    idle_enable = 1'b0;
	bit                    sender_paused = 1'b0;
	int                    send_gap = 0;
	int                    stall_left = 0;
	int                    receiver_hold = 0;
	int                    mismatch_count = 0;
	int                    ticks_seen = 0;
	int                    restarts_seen = 0;
	int                    results_checked = 0;
	int                    cfg_writes = 0;

	// Predicted register file and light state.
	logic [GREEN_W-1:0]    green_ns_cfg;
	logic [GREEN_W-1:0]    green_eo_cfg;
	logic [PHASE_W-1:0]    orange_cfg;
	logic [PHASE_W-1:0]    allred_cfg;
	color_t                ns_color;
	color_t                eo_color;
	logic [TIMER_W-1:0]    ns_left;
	logic [TIMER_W-1:0]    eo_left;

	two_axis_traffic_light_timer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.color_ns     (color_ns),
		.color_eo     (color_eo),
		.remaining_ns (remaining_ns),
		.remaining_eo (remaining_eo),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int random_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	// Initial phase: north-south green, east-west red until north-south clears.
	task automatic reload_lights();
		ns_color = COL_GREEN;
		eo_color = COL_RED;
		ns_left  = TIMER_W'(green_ns_cfg);
		eo_left  = TIMER_W'(green_ns_cfg) + TIMER_W'(orange_cfg) + TIMER_W'(allred_cfg);
	endtask

	// One axis counts down; at one or zero it moves to its next color.
	task automatic tick_axis(inout color_t col, inout logic [TIMER_W-1:0] left,
			input logic [GREEN_W-1:0] own_green, input logic [GREEN_W-1:0] other_green);
		if (left <= 1) begin
			case (col)
				COL_GREEN: begin
					col  = COL_ORANGE;
					left = TIMER_W'(orange_cfg);
				end
				COL_ORANGE: begin
					col  = COL_RED;
					left = TIMER_W'(ALLRED_PER_CYCLE * allred_cfg) + TIMER_W'(orange_cfg)
						+ TIMER_W'(other_green);
				end
				default: begin
					col  = COL_GREEN;
					left = TIMER_W'(own_green);
				end
			endcase
		end else begin
			left = left - 1'b1;
		end
	endtask

	// Applies one tick or restart and queues the lights it should produce.
	task automatic advance_lights(input bit is_restart);
		light_report_t report;
		if (is_restart) begin
			reload_lights();
		end else begin
			tick_axis(ns_color, ns_left, green_ns_cfg, green_eo_cfg);
			tick_axis(eo_color, eo_left, green_eo_cfg, green_ns_cfg);
		end
		report.ns      = ns_color;
		report.eo      = eo_color;
		report.ns_left = ns_left;
		report.eo_left = eo_left;
		expected_lights.push_back(report);
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Tick driver: holds a stalled transfer, otherwise offers the next queued tick.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !tick_taken) begin
			// The block has not taken the offered tick yet, so it stays put.
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (sender_paused || tick_queue.size() == 0) begin
			in_valid <= 1'b0;
		end else begin
			in_valid <= 1'b1;
			restart  <= tick_queue.pop_front();
			send_gap = idle_enable ? random_gap() : 0;
		end
		tick_taken = 1'b0;
	end

	// Result receiver: a requested long hold first, then random stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (receiver_hold > 0) begin
			out_stall <= 1'b1;
			receiver_hold--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = idle_enable ? random_gap() : 0;
		end
	end

	// Monitor: checks each result transfer, predicts each tick, tracks writes.
	always @(posedge clk) begin
		light_report_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_lights.size() == 0) begin
					$display("%0t: unexpected result, actual ns %0d/%0d eo %0d/%0d", $time,
						color_ns, remaining_ns, color_eo, remaining_eo);
					mismatch_count++;
				end else begin
					want = expected_lights.pop_front();
					check_field("color_ns", want.ns, color_ns);
					check_field("color_eo", want.eo, color_eo);
					check_field("remaining_ns", want.ns_left, remaining_ns);
					check_field("remaining_eo", want.eo_left, remaining_eo);
					results_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				advance_lights(restart);
				tick_taken = 1'b1;
				ticks_seen++;
				if (restart) restarts_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GREEN_NS:    green_ns_cfg = cfg_data;
					REG_GREEN_EO:    green_eo_cfg = cfg_data;
					REG_ORANGE_TIME: orange_cfg   = cfg_data[PHASE_W-1:0];
					REG_ALLRED_TIME: allred_cfg   = cfg_data[PHASE_W-1:0];
					default: ;
				endcase
				cfg_writes++;
			end
		end
	end

	task automatic write_register(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [CFG_DW-1:0] g_ns, input logic [CFG_DW-1:0] g_eo,
			input logic [CFG_DW-1:0] orange, input logic [CFG_DW-1:0] allred);
		write_register(REG_GREEN_NS, g_ns);
		write_register(REG_GREEN_EO, g_eo);
		write_register(REG_ORANGE_TIME, orange);
		write_register(REG_ALLRED_TIME, allred);
	endtask

	task automatic queue_ticks(input int count, input int restart_pct);
		repeat (count) tick_queue.push_back($urandom_range(0, 99) < restart_pct);
	endtask

	// Waits until every queued tick has gone in and every result has come back.
	task automatic wait_drained();
		do @(posedge clk);
		while (tick_queue.size() != 0 || in_valid || expected_lights.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [CFG_DW-1:0] random_green();
		if ($urandom_range(0, 3) == 0) return CFG_DW'($urandom_range(1, 255));
		return CFG_DW'($urandom_range(1, 24));
	endfunction

	// Main sequence.
	initial begin
		green_ns_cfg = RST_GREEN_NS;
		green_eo_cfg = RST_GREEN_EO;
		orange_cfg   = RST_ORANGE_TIME;
		allred_cfg   = RST_ALLRED_TIME;
		reload_lights();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset values, back-to-back ticks through a full green and orange,
		// then a restart in the middle of the cycle.
		tick_queue.push_back(1'b1);
		repeat (18) tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b1);
		repeat (5) tick_queue.push_back(1'b0);
		wait_drained();

		// Shortest legal phases with no all-red overlap.
		write_all(8'd1, 8'd1, 8'd1, 8'd0);
		idle_enable = 1'b1;
		queue_ticks(60, 3);
		wait_drained();

		// Zero lengths: counters sitting at zero must advance, not wrap. The upper
		// data bits are set so the narrow registers must drop them.
		write_all(8'd0, 8'd0, 8'hF0, 8'hA0);
		queue_ticks(40, 5);
		wait_drained();

		// Longest phases, run long enough for a red load of 300.
		write_all(8'd255, 8'd255, 8'h0F, 8'h3F);
		tick_queue.push_back(1'b1);
		queue_ticks(330, 0);
		wait_drained();

		// Random settings, some phases without any idling.
		for (int phase = 0; phase < 8; phase++) begin
			write_all(random_green(), random_green(),
				{4'($urandom), 4'($urandom_range(1, 15))},
				{4'($urandom), 4'($urandom_range(0, 15))});
			idle_enable = (phase % 3) != 0;
			queue_ticks(60, 4);
			if (phase == 1) begin
				// Long receiver hold so the block fills up and pushes back.
				receiver_hold = 80;
			end
			if (phase == 2) begin
				// Sender stops mid-phase until the block has emptied.
				do @(posedge clk); while (tick_queue.size() > 30);
				sender_paused = 1'b1;
				do @(posedge clk); while (in_valid || expected_lights.size() != 0);
				sender_paused = 1'b0;
			end
			wait_drained();
		end

		$display("Checked %0d results from %0d ticks (%0d restarts) over %0d register writes,",
			results_checked, ticks_seen, restarts_seen, cfg_writes);
		$display("with minimum, zero, maximum and random phase lengths under stalls and gaps.");
		if (mismatch_count == 0 && expected_lights.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
